FILE: design/pool_linked_list_engine_unit_assert.svh
// Assertion macros for the RTL that checks itself.
`ifndef POOL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define POOL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/plle_pkg.sv
`default_nettype none
package plle_pkg;

    localparam int POOL_DEPTH  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int IDX_W       = 7;

    localparam logic [IDX_W-1:0] NIL_IDX = 7'h7F;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_HEAD  = 3'd1;
    localparam logic [2:0] CMD_TAIL  = 3'd2;
    localparam logic [2:0] CMD_POS   = 3'd3;
    localparam logic [2:0] CMD_REM   = 3'd4;
    localparam logic [2:0] CMD_DUMP  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [2:0] cmd;
        t_val       value;
        logic [6:0] pos;
    } t_cmd;

    typedef struct packed {
        t_idx len;
        t_idx alloc;
    } t_bstat;

endpackage
`default_nettype wire

FILE: design/pool_linked_list_engine_unit.sv
`default_nettype none
// Linked list in a 64-node pool. Commands enter a two-entry queue and are
// executed one at a time. Tail insert, positional insert, removal and dump
// walk the list one node per cycle through the node memory's registered
// read port. A dump gives one result per node and stalls its walk while
// the output register is held.
`include "pool_linked_list_engine_unit_assert.svh"
module pool_linked_list_engine_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [2:0]          i_command,
    input  wire  signed [31:0]  i_value,
    input  wire  [6:0]          i_position,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic signed [31:0]  o_item_value,
    output logic                o_last,
    output logic                o_empty_res,
    output logic [1:0]          o_status
);
    import plle_pkg::*;

    logic   q_valid, q_ready;
    t_cmd   q_cmd;
    t_bstat stat;

    plle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_value(i_value), .i_position(i_position),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_cmd(q_cmd)
    );

    plle_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_cmd(q_cmd),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_item_value(o_item_value), .o_last(o_last),
        .o_empty_res(o_empty_res), .o_status(o_status), .o_stat(stat)
    );

    `PLLE_ASSERT_IMPL(a_len_le_alloc, i_clk, i_rst_n, 1'b1, stat.len <= stat.alloc, "list longer than allocation")
    `PLLE_ASSERT_IMPL(a_alloc_bound, i_clk, i_rst_n, 1'b1, {1'b0, stat.alloc} <= (IDX_W+1)'(POOL_DEPTH), "allocator past pool")
    `PLLE_ASSERT_IMPL(a_empty_res, i_clk, i_rst_n, o_out_valid && o_empty_res, o_last && o_status == ST_EMPTY && o_item_value == 32'sd0, "bad empty dump result")
    `PLLE_ASSERT_IMPL(a_fail_last, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_last, "failed command not single result")
    `PLLE_ASSERT_NEXT(a_clear, i_clk, i_rst_n, q_valid && q_ready && q_cmd.cmd == CMD_CLEAR, stat.len == '0 && stat.alloc == '0, "clear did not reset pool")

endmodule
`default_nettype wire

FILE: design/plle_front.sv
`default_nettype none
module plle_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [2:0]           i_command,
    input  wire  signed [31:0]   i_value,
    input  wire  [6:0]           i_position,
    output logic                 o_q_valid,
    input  wire                  i_q_ready,
    output plle_pkg::t_cmd       o_q_cmd
);
    import plle_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;
    t_cmd       in_cmd;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    // drop unused command codes at the door
    assign push = i_in_valid && o_in_ready && (i_command <= CMD_DUMP);
    assign pop  = o_q_valid && i_q_ready;

    always_comb begin
        in_cmd.cmd   = i_command;
        in_cmd.value = VALUE_WIDTH'(i_value);
        in_cmd.pos   = i_position;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= in_cmd;
    end

endmodule
`default_nettype wire

FILE: design/plle_back.sv
`default_nettype none
module plle_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    output logic                 o_q_ready,
    input  wire plle_pkg::t_cmd  i_q_cmd,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic signed [31:0]   o_item_value,
    output logic                 o_last,
    output logic                 o_empty_res,
    output logic [1:0]           o_status,
    output plle_pkg::t_bstat     o_stat
);
    import plle_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_INS_A = 3'd2;
    localparam logic [2:0] S_INS_B = 3'd3;
    localparam logic [2:0] S_RSCAN = 3'd4;
    localparam logic [2:0] S_DUMP  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    t_val mem_val  [POOL_DEPTH];
    t_idx mem_link [POOL_DEPTH];
    t_val m_val;
    t_idx m_link;

    logic [2:0] r_state, n_state;
    t_idx r_head, n_head, r_alloc, n_alloc, r_len, n_len;
    t_idx r_p, n_p, r_prev, n_prev, r_cnt, n_cnt;
    logic [2:0] r_op, n_op;
    t_val r_v, n_v;
    logic r_hd, n_hd, r_first, n_first, r_emp, n_emp;
    logic [1:0] r_st, n_st;

    logic r_ovalid, n_ovalid, r_olast, n_olast, r_oemp, n_oemp;
    logic signed [31:0] r_oval, n_oval;
    logic [1:0] r_ost, n_ost;

    logic slot_free;
    logic we_val, we_link;
    t_idx wa_val, wa_link;
    t_idx wd_link;

    assign slot_free    = !r_ovalid || i_out_ready;
    assign o_q_ready    = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_item_value = r_oval;
    assign o_last       = r_olast;
    assign o_empty_res  = r_oemp;
    assign o_status     = r_ost;
    assign o_stat.len   = r_len;
    assign o_stat.alloc = r_alloc;

    always_comb begin
        n_state = r_state; n_head = r_head; n_alloc = r_alloc; n_len = r_len;
        n_p = r_p; n_prev = r_prev; n_cnt = r_cnt; n_op = r_op; n_v = r_v;
        n_hd = r_hd; n_first = r_first; n_emp = r_emp; n_st = r_st;
        n_ovalid = r_ovalid && !i_out_ready;
        n_oval = r_oval; n_olast = r_olast; n_oemp = r_oemp; n_ost = r_ost;
        we_val = 1'b0; we_link = 1'b0;
        wa_val = r_alloc; wa_link = r_alloc; wd_link = NIL_IDX;

        case (r_state)
            S_IDLE: begin
                n_p = r_head;
                if (i_q_valid) begin
                    n_op = i_q_cmd.cmd; n_v = i_q_cmd.value;
                    n_emp = 1'b0; n_st = ST_OK; n_first = 1'b1;
                    n_state = S_RESP;
                    case (i_q_cmd.cmd)
                        CMD_CLEAR: begin
                            n_head = NIL_IDX; n_alloc = '0; n_len = '0;
                        end
                        CMD_HEAD, CMD_TAIL, CMD_POS: begin
                            if ({1'b0, r_alloc} >= (IDX_W+1)'(POOL_DEPTH)) begin
                                n_st = ST_FULL;
                            end else if (i_q_cmd.cmd == CMD_POS &&
                                         (i_q_cmd.pos == 7'd0 ||
                                          {1'b0, i_q_cmd.pos} > {1'b0, r_len} + 8'd1)) begin
                                n_st = ST_RANGE;
                            end else if (i_q_cmd.cmd == CMD_HEAD || r_head == NIL_IDX ||
                                         (i_q_cmd.cmd == CMD_POS && i_q_cmd.pos == 7'd1)) begin
                                n_hd = 1'b1; n_state = S_INS_A;
                            end else begin
                                n_hd = 1'b0; n_state = S_WALK;
                                n_cnt = (i_q_cmd.cmd == CMD_TAIL) ? r_len - 7'd1
                                                                  : i_q_cmd.pos - 7'd2;
                            end
                        end
                        CMD_REM: begin
                            if (r_len == '0) n_st = ST_EMPTY;
                            else             n_state = S_RSCAN;
                        end
                        CMD_DUMP: begin
                            if (r_len == '0) begin
                                n_st = ST_EMPTY; n_emp = 1'b1;
                            end else begin
                                n_cnt = r_len; n_state = S_DUMP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = S_INS_A;
                end else begin
                    n_p = m_link; n_cnt = r_cnt - 7'd1;
                end
            end
            S_INS_A: begin
                we_val = 1'b1; we_link = 1'b1;
                if (r_op == CMD_TAIL) wd_link = NIL_IDX;
                else if (r_hd)        wd_link = r_head;
                else                  wd_link = m_link;
                if (r_hd) begin
                    n_head = r_alloc; n_alloc = r_alloc + 7'd1; n_len = r_len + 7'd1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_INS_B;
                end
            end
            S_INS_B: begin
                we_link = 1'b1; wa_link = r_p; wd_link = r_alloc;
                n_alloc = r_alloc + 7'd1; n_len = r_len + 7'd1;
                n_state = S_RESP;
            end
            S_RSCAN: begin
                if (m_val == r_v) begin
                    if (r_first) n_head = m_link;
                    else begin
                        we_link = 1'b1; wa_link = r_prev; wd_link = m_link;
                    end
                    n_len = r_len - 7'd1; n_st = ST_OK; n_state = S_RESP;
                end else if (m_link == NIL_IDX) begin
                    n_st = ST_EMPTY; n_state = S_RESP;
                end else begin
                    n_prev = r_p; n_p = m_link; n_first = 1'b0;
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    n_ovalid = 1'b1; n_oval = 32'(m_val); n_olast = (r_cnt == 7'd1);
                    n_oemp = 1'b0; n_ost = ST_OK;
                    n_p = m_link; n_cnt = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_ovalid = 1'b1; n_oval = '0; n_olast = 1'b1;
                    n_oemp = r_emp; n_ost = r_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL_IDX;
            r_alloc  <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_alloc  <= n_alloc;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_prev <= n_prev; r_cnt <= n_cnt; r_op <= n_op; r_v <= n_v;
        r_hd <= n_hd; r_first <= n_first; r_emp <= n_emp; r_st <= n_st;
        r_oval <= n_oval; r_olast <= n_olast; r_oemp <= n_oemp; r_ost <= n_ost;
    end

    // node pool: read follows the next walk pointer, so m_* always hold node r_p
    always_ff @(posedge i_clk) begin
        if (we_val)  mem_val[wa_val[ADDR_W-1:0]]   <= r_v;
        if (we_link) mem_link[wa_link[ADDR_W-1:0]] <= wd_link;
        m_val  <= mem_val[n_p[ADDR_W-1:0]];
        m_link <= mem_link[n_p[ADDR_W-1:0]];
    end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import plle_pkg::*;

    typedef struct {
        logic signed [31:0] item_value;
        logic               last;
        logic               empty_res;
        logic [1:0]         status;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_command;
    logic signed [31:0] i_value;
    logic [6:0]         i_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_item_value;
    logic               o_last;
    logic               o_empty_res;
    logic [1:0]         o_status;

    pool_linked_list_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_value(i_value), .i_position(i_position),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_item_value(o_item_value), .o_last(o_last),
        .o_empty_res(o_empty_res), .o_status(o_status)
    );

    // shadow of the node pool
    logic signed [31:0] pool_vals [POOL_DEPTH];
    logic [6:0]         pool_next [POOL_DEPTH];
    logic [6:0]         list_head;
    int                 nodes_used;
    int                 list_len;

    t_list_result pending_results[$];
    int           error_count;
    bit           long_hold;
    int           burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    task automatic push_result(logic signed [31:0] v, logic l, logic e, logic [1:0] s);
        t_list_result r;
        r.item_value = v;
        r.last       = l;
        r.empty_res  = e;
        r.status     = s;
        pending_results.push_back(r);
    endtask

    // advance the shadow list and queue what the command should produce
    task automatic predict_list(logic [2:0] cmd, logic signed [31:0] val, logic [6:0] pos);
        logic [6:0] n;
        logic [6:0] p;
        logic [1:0] st;
        int         k;
        st = ST_OK;
        case (cmd)
            CMD_CLEAR: begin
                list_head  = NIL_IDX;
                nodes_used = 0;
                list_len   = 0;
            end
            CMD_HEAD, CMD_TAIL, CMD_POS: begin
                if (nodes_used >= POOL_DEPTH) begin
                    st = ST_FULL;
                end else if (cmd == CMD_POS && (pos < 1 || pos > list_len + 1)) begin
                    st = ST_RANGE;
                end else begin
                    n = 7'(nodes_used);
                    pool_vals[n] = val;
                    pool_next[n] = NIL_IDX;
                    nodes_used++;
                    if (cmd == CMD_HEAD || (cmd == CMD_POS && pos == 1) ||
                        list_head == NIL_IDX) begin
                        if (cmd != CMD_TAIL) pool_next[n] = list_head;
                        list_head = n;
                    end else if (cmd == CMD_TAIL) begin
                        p = list_head;
                        for (k = 0; k < list_len - 1; k++) p = pool_next[p];
                        pool_next[p] = n;
                    end else begin
                        p = list_head;
                        for (k = 0; k < pos - 2; k++) p = pool_next[p];
                        pool_next[n] = pool_next[p];
                        pool_next[p] = n;
                    end
                    list_len++;
                end
            end
            CMD_REM: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (pool_vals[list_head] == val) begin
                    list_head = pool_next[list_head];
                    list_len--;
                end else begin
                    st = ST_EMPTY;
                    p = list_head;
                    while (pool_next[p] != NIL_IDX) begin
                        n = pool_next[p];
                        if (pool_vals[n] == val) begin
                            pool_next[p] = pool_next[n];
                            list_len--;
                            st = ST_OK;
                            break;
                        end
                        p = n;
                    end
                end
            end
            CMD_DUMP: begin
                if (list_len == 0) begin
                    push_result(0, 1'b1, 1'b1, ST_EMPTY);
                end else begin
                    p = list_head;
                    for (k = 0; k < list_len; k++) begin
                        push_result(pool_vals[p], k == list_len - 1, 1'b0, ST_OK);
                        p = pool_next[p];
                    end
                end
                return;
            end
            default: return;
        endcase
        push_result(0, 1'b1, 1'b0, st);
    endtask

    // drop valid and scramble the payload while idle
    task automatic release_input();
        i_in_valid <= 1'b0;
        i_command  <= 3'($urandom);
        i_value    <= $urandom;
        i_position <= 7'($urandom);
    endtask

    // sender works in bursts with random gaps between them
    task automatic send_command(logic [2:0] cmd, logic signed [31:0] val, logic [6:0] pos);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                release_input();
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        predict_list(cmd, val, pos);
    endtask

    task automatic wait_drained();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return 32'($urandom_range(0, 15)) - 8;
        endcase
    endfunction

    task automatic test_directed();
        send_command(CMD_DUMP, 0, 1);
        send_command(CMD_REM, 5, 1);
        send_command(CMD_POS, 1, 0);
        send_command(CMD_POS, 1, 2);
        send_command(CMD_TAIL, 32'sh7FFFFFFF, 7'h7F);
        send_command(CMD_HEAD, 32'sh80000000, 1);
        send_command(CMD_POS, -1, 3);
        send_command(CMD_POS, 42, 1);
        send_command(CMD_POS, 7, 3);
        send_command(CMD_POS, 9, 7);
        send_command(3'd6, 1, 1);
        send_command(3'd7, 1, 1);
        send_command(CMD_DUMP, 0, 1);
        send_command(CMD_REM, 42, 1);
        send_command(CMD_REM, 32'sh7FFFFFFF, 1);
        send_command(CMD_REM, 1234, 1);
        send_command(CMD_DUMP, 0, 1);
        send_command(CMD_CLEAR, 0, 1);
        send_command(CMD_DUMP, 0, 1);
        wait_drained();
    endtask

    // fill the pool to the last node, hit the full flag, dump 64 items, remove one, dump again
    task automatic test_pool_full();
        int k;
        send_command(CMD_CLEAR, 0, 1);
        for (k = 0; k < POOL_DEPTH; k++)
            send_command(k[0] ? CMD_TAIL : CMD_HEAD, $urandom, 1);
        send_command(CMD_HEAD, 1, 1);
        send_command(CMD_TAIL, 1, 1);
        send_command(CMD_POS, 1, 7'd64);
        send_command(CMD_DUMP, 0, 1);
        send_command(CMD_REM, pool_vals[63], 1);
        send_command(CMD_DUMP, 0, 1);
        wait_drained();
    endtask

    // receiver blocked while sender keeps offering
    task automatic test_backpressure();
        int k;
        long_hold = 1'b1;
        for (k = 0; k < 6; k++) send_command(CMD_DUMP, 0, 1);
        wait_drained();
    endtask

    task automatic test_random();
        int      k;
        logic [2:0] cmd;
        for (k = 0; k < 280; k++) begin
            if (nodes_used >= POOL_DEPTH - 2 && $urandom_range(0, 3) != 0)
                cmd = CMD_CLEAR;
            else begin
                case ($urandom_range(0, 19))
                    0:              cmd = CMD_CLEAR;
                    1, 2, 3:        cmd = CMD_HEAD;
                    4, 5, 6:        cmd = CMD_TAIL;
                    7, 8, 9, 10:    cmd = CMD_POS;
                    11, 12, 13, 14: cmd = CMD_REM;
                    15, 16, 17:     cmd = CMD_DUMP;
                    default:        cmd = 3'($urandom_range(6, 7));
                endcase
            end
            send_command(cmd, pick_value(),
                         ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                                     : 7'($urandom_range(0, list_len + 2)));
            if (k % 90 == 45) wait_drained();
        end
        wait_drained();
    endtask

    initial begin : stall_pattern
        int hold_cycles;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge i_clk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 9) < 3) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_item_value !== exp_r.item_value) begin
                    $error("item_value expected %0d actual %0d", exp_r.item_value,
                           o_item_value);
                    error_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last expected %0d actual %0d", exp_r.last, o_last);
                    error_count++;
                end
                if (o_empty_res !== exp_r.empty_res) begin
                    $error("empty_res expected %0d actual %0d", exp_r.empty_res,
                           o_empty_res);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count = 0;
        long_hold   = 1'b0;
        burst_left  = 0;
        list_head   = NIL_IDX;
        nodes_used  = 0;
        list_len    = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_CLEAR;
        i_value     = 0;
        i_position  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/plle_pkg.sv
design/plle_front.sv
design/plle_back.sv
design/pool_linked_list_engine_unit.sv
test/tb_top.sv
